// File: sv/tst_pkg.sv
// types and constants shared by the timing statistics table
package tst_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned ID_W       = 4;
    localparam int unsigned MEAN_SHIFT = 4;

    typedef enum logic [1:0] {
        FN_RECORD = 2'd0,
        FN_READ   = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_BUDGET = 2'd3
    } t_tst_func;

    typedef struct packed {
        t_tst_func           func;
        logic [ID_W-1:0]     entry_id;
        logic [DATA_W-1:0]   value_us;
    } t_tst_req;

    typedef struct packed {
        logic                id_ok;
        logic [DATA_W-1:0]   sample_count;
        logic [DATA_W-1:0]   last_time;
        logic [DATA_W-1:0]   max_time;
        logic [DATA_W-1:0]   mean_time;
        logic [DATA_W-1:0]   budget_time;
        logic [DATA_W-1:0]   overrun_total;
        logic                over_budget_now;
    } t_tst_rsp;

endpackage

// File: sv/tst_stream_if.sv
// valid/ready stream channel carrying one word of type t_data
interface tst_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/timing_stats_table.sv
// a request word is held in the input register, its response in the output register
// throughput: one word per cycle while o_rsp is ready; the entry read, update and
// write-back happen in the same cycle, so a word that follows on the same entry sees
// the previous update; reset (synchronous, active low) clears every entry including
// its budget and empties the input and output registers
module timing_stats_table #(
    parameter int unsigned NUM_ENTRIES = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tst_stream_if.sink    i_req,
    tst_stream_if.source  o_rsp
);
    import tst_pkg::*;

    localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic                r_in_vld;
    t_tst_req            r_in;
    logic                r_out_vld;
    t_tst_rsp            r_out;

    logic [DATA_W-1:0]   r_count   [NUM_ENTRIES];
    logic [DATA_W-1:0]   r_last    [NUM_ENTRIES];
    logic [DATA_W-1:0]   r_max     [NUM_ENTRIES];
    logic [DATA_W-1:0]   r_mean    [NUM_ENTRIES];
    logic [DATA_W-1:0]   r_budget  [NUM_ENTRIES];
    logic [DATA_W-1:0]   r_overrun [NUM_ENTRIES];

    logic                adv;
    logic                in_take;
    logic                id_ok;
    logic [IDX_W-1:0]    idx;
    logic [DATA_W-1:0]   cur_count, cur_last, cur_max, cur_mean, cur_budget, cur_overrun;
    logic [DATA_W-1:0]   n_count, n_last, n_max, n_mean, n_budget, n_overrun;
    logic [DATA_W-1:0]   cnt_inc, diff_up, diff_dn, smp;
    logic                smp_ge;
    t_tst_rsp            n_rsp;

    assign adv     = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign in_take = i_req.valid && i_req.ready;

    assign i_req.ready = !r_in_vld || adv;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    assign id_ok = ({1'b0, r_in.entry_id} < (ID_W + 1)'(NUM_ENTRIES));
    assign idx   = r_in.entry_id[IDX_W-1:0];
    assign smp   = r_in.value_us;

    assign cur_count   = r_count[idx];
    assign cur_last    = r_last[idx];
    assign cur_max     = r_max[idx];
    assign cur_mean    = r_mean[idx];
    assign cur_budget  = r_budget[idx];
    assign cur_overrun = r_overrun[idx];

    assign cnt_inc = cur_count + DATA_W'(1);
    assign smp_ge  = (smp >= cur_mean);
    assign diff_up = smp - cur_mean;
    assign diff_dn = cur_mean - smp;

    always_comb begin
        n_count   = cur_count;
        n_last    = cur_last;
        n_max     = cur_max;
        n_mean    = cur_mean;
        n_budget  = cur_budget;
        n_overrun = cur_overrun;
        unique case (r_in.func)
            FN_RECORD: begin
                n_count = cnt_inc;
                n_last  = smp;
                if (smp > cur_max) begin
                    n_max = smp;
                end
                // first sample loads the mean, later ones move it a sixteenth of the gap
                if (cnt_inc == DATA_W'(1)) begin
                    n_mean = smp;
                end else if (smp_ge) begin
                    n_mean = cur_mean + (diff_up >> MEAN_SHIFT);
                end else begin
                    n_mean = cur_mean - (diff_dn >> MEAN_SHIFT);
                end
                if (cur_budget != '0 && smp > cur_budget) begin
                    n_overrun = cur_overrun + DATA_W'(1);
                end
            end
            FN_READ: begin
            end
            FN_CLEAR: begin
                n_count   = '0;
                n_last    = '0;
                n_max     = '0;
                n_mean    = '0;
                n_overrun = '0;
            end
            FN_BUDGET: begin
                n_budget = smp;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_rsp = '0;
        if (id_ok) begin
            n_rsp.id_ok           = 1'b1;
            n_rsp.sample_count    = n_count;
            n_rsp.last_time       = n_last;
            n_rsp.max_time        = n_max;
            n_rsp.mean_time       = n_mean;
            n_rsp.budget_time     = n_budget;
            n_rsp.overrun_total   = n_overrun;
            n_rsp.over_budget_now = (n_budget != '0) && (n_last > n_budget);
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
        if (in_take) begin
            r_in <= i_req.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (adv) begin
            r_out <= n_rsp;
        end
    end

    // statistics table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_count[i]   <= '0;
                r_last[i]    <= '0;
                r_max[i]     <= '0;
                r_mean[i]    <= '0;
                r_budget[i]  <= '0;
                r_overrun[i] <= '0;
            end
        end else if (adv && id_ok) begin
            r_count[idx]   <= n_count;
            r_last[idx]    <= n_last;
            r_max[idx]     <= n_max;
            r_mean[idx]    <= n_mean;
            r_budget[idx]  <= n_budget;
            r_overrun[idx] <= n_overrun;
        end
    end

endmodule

// File: sv/tst_checker.sv
// port-level assertions for the timing statistics table, with its bind
module tst_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input tst_pkg::t_tst_rsp i_rsp_data
);
    import tst_pkg::*;

    // nothing is offered straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("response offered after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("stalled response changed");

    a_bad_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.id_ok |->
            i_rsp_data.sample_count == '0 && i_rsp_data.last_time == '0 &&
            i_rsp_data.max_time == '0 && i_rsp_data.mean_time == '0 &&
            i_rsp_data.budget_time == '0 && i_rsp_data.overrun_total == '0 &&
            !i_rsp_data.over_budget_now)
        else $error("invalid entry gave nonzero stats");

    a_over_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data.over_budget_now ==
            (i_rsp_data.budget_time != '0 &&
             i_rsp_data.last_time > i_rsp_data.budget_time))
        else $error("over-budget flag disagrees with budget and last time");

    a_max_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data.max_time >= i_rsp_data.last_time)
        else $error("maximum below last time");

endmodule

bind timing_stats_table tst_checker u_tst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);
